// ===== design/sensor_table_linear_interpolation_top_assert.svh =====
// Assertion macros for the sensor table interpolation RTL.
`ifndef SENSOR_TABLE_LINEAR_INTERPOLATION_TOP_ASSERT_SVH
`define SENSOR_TABLE_LINEAR_INTERPOLATION_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STLI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stli_pkg.sv =====
// Types, constants and helpers for the sensor table interpolation block.
package stli_pkg;

    localparam int VOLT_W      = 24;
    localparam int KNOT_W      = 16;
    localparam int TEMP_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 7;
    localparam int IDX_IN_W    = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    // A knot scaled to microvolts fits in 23 bits.
    localparam int UV_W        = 23;
    localparam int PROD_W      = UV_W + TEMP_W;
    localparam int UV_PER_UNIT = 100;

    localparam int DEFAULT_MAX_POINTS = 64;

    localparam logic ACT_CONVERT = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_TEMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_TEMP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_IN_RANGE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMP_HI = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLAMP_LO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CFG_ERR  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HI,
        S_LO,
        S_WALK,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_FIN
    } t_state;

    function automatic logic [UV_W-1:0] knot_to_uv(input logic [KNOT_W-1:0] k);
        return UV_W'(32'(k) * UV_PER_UNIT);
    endfunction

endpackage

// ===== design/stli_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module stli_div
    import stli_pkg::*;
#(
    parameter int DEN_W = UV_W,
    parameter int Q_W   = TEMP_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DEN_W+Q_W-1:0]   i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic                   o_done,
    output logic [Q_W-1:0]         o_quot
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_low;

    logic [DEN_W:0]   trial;
    logic             ge;

    // The caller guarantees the quotient fits in Q_W bits, so the upper part
    // of the dividend is already below the divisor.
    assign trial = {r_rem, r_low[Q_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(Q_W);
                r_rem  <= i_num[DEN_W+Q_W-1:Q_W];
                r_low  <= i_num[Q_W-1:0];
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= ge ? DEN_W'(trial - {1'b0, r_den}) : DEN_W'(trial);
                r_low  <= {r_low[Q_W-2:0], ge};
                r_cnt  <= r_cnt - CNT_W'(1);
                r_busy <= (r_cnt != CNT_W'(1));
                r_done <= (r_cnt == CNT_W'(1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

// ===== design/sensor_table_linear_interpolation_top.sv =====
// Sensor table interpolation: converts microvolts to temperature over a knot table.
//
// Input channel (i_in_valid / o_in_stall) carries one item per beat. A load
// beat (i_action high) writes i_knot_voltage at i_knot_index, if inside the
// table, and gives no result. A convert beat gives exactly one result beat on
// the output channel (o_out_valid / i_out_stall) with o_temperature and o_status.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must do so only while the block is idle; the block does not enforce it.
// A convert with a bad configuration goes straight to its result; else the
// voltage is checked against the first knot (clamp high), then the last knot
// (clamp low), then the knots are read one per cycle from the knot memory down
// to the first knot at or below the voltage. A voltage equal to the first knot
// needs no division; otherwise the divider yields one quotient bit per cycle.
// The result is registered, and the next beat is accepted in the cycle after.
// One item is worked on at a time; a finished result sits in the output
// register, so the next item is accepted while that result waits.
// When the receiver stalls, the result holds in the output register and the
// block waits before writing the next result there.
// Reset clears the configuration registers and the control state; the knot
// memory is not cleared and each knot must be loaded before it is used.
module sensor_table_linear_interpolation_top
    import stli_pkg::*;
#(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [VOLT_W-1:0]     i_voltage_uv,
    input  logic [IDX_IN_W-1:0]   i_knot_index,
    input  logic [KNOT_W-1:0]     i_knot_voltage,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TEMP_W-1:0]     o_temperature,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = AW + 1;

    `include "sensor_table_linear_interpolation_top_assert.svh"

    // Configuration
    logic [COUNT_W-1:0] r_point_count;
    logic [TEMP_W-1:0]  r_first;
    logic [TEMP_W-1:0]  r_second;

    // Control and work registers
    t_state             r_state, n_state;
    logic [VOLT_W-1:0]  r_v;
    logic [CW-1:0]      r_idx;
    logic [UV_W-1:0]    r_prev;
    logic [UV_W-1:0]    r_den;
    logic [PROD_W-1:0]  r_num;
    logic [TEMP_W-1:0]  r_temp;
    logic [STATUS_W-1:0] r_status;

    logic                r_out_valid;
    logic [TEMP_W-1:0]   r_out_temp;
    logic [STATUS_W-1:0] r_out_status;

    // Knot memory
    logic [KNOT_W-1:0] mem [MAX_POINTS];
    logic [KNOT_W-1:0] r_rd_data;
    logic [AW-1:0]     rd_addr;

    logic              in_acc;
    logic              in_stall;
    logic              out_free;
    logic [CW-1:0]     n;
    logic [CW-1:0]     n_m1;
    logic              cfg_err;
    logic [TEMP_W-1:0] step;
    logic [UV_W-1:0]   knot_uv;
    logic              v_gt;
    logic              v_lt;
    logic              walk_stop;
    logic [CW-1:0]     seg;
    logic [UV_W-1:0]   hv_diff;
    logic              div_start;
    logic              div_done;
    logic [TEMP_W-1:0] div_quot;

    assign in_acc   = i_in_valid && !in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Point count limited to the table depth.
    assign n       = (32'(r_point_count) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                      : CW'(r_point_count);
    assign n_m1    = n - CW'(1);
    assign cfg_err = (n == '0) || (r_first >= r_second);
    assign step    = r_second - r_first;

    assign knot_uv   = knot_to_uv(r_rd_data);
    assign v_gt      = r_v > VOLT_W'(knot_uv);
    assign v_lt      = r_v < VOLT_W'(knot_uv);
    assign walk_stop = !((r_idx < n_m1) && v_lt);
    assign seg       = (r_idx == '0) ? '0 : r_idx - CW'(1);
    // The voltage lies below the upper knot of the segment here.
    assign hv_diff   = UV_W'(VOLT_W'(r_prev) - r_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_first       <= '0;
            r_second      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POINT_COUNT: r_point_count <= i_cfg_data[COUNT_W-1:0];
                REG_FIRST_TEMP:  r_first       <= i_cfg_data[TEMP_W-1:0];
                REG_SECOND_TEMP: r_second      <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_action == ACT_LOAD && 32'(i_knot_index) < MAX_POINTS) begin
            mem[AW'(i_knot_index)] <= i_knot_voltage;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_action == ACT_CONVERT) begin
                    n_state = cfg_err ? S_FIN : S_HI;
                end
            end
            S_HI:     n_state = v_gt ? S_FIN : S_LO;
            S_LO:     n_state = v_lt ? S_FIN : S_WALK;
            S_WALK: begin
                if (walk_stop) begin
                    n_state = (r_idx == '0) ? S_FIN : S_MUL;
                end
            end
            S_MUL:    n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  n_state = div_done ? S_FIN : S_DWAIT;
            S_FIN:    n_state = out_free ? S_IDLE : S_FIN;
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs: stall, memory read address, divider start
    always_comb begin
        in_stall  = 1'b1;
        rd_addr   = '0;
        div_start = 1'b0;
        case (r_state)
            S_IDLE: in_stall = 1'b0;
            S_HI:   rd_addr  = n_m1[AW-1:0];
            S_LO:   rd_addr  = '0;
            S_WALK: begin
                rd_addr = CW'(r_idx + CW'(1)) >= CW'(MAX_POINTS) ? '0
                                                                 : AW'(r_idx + CW'(1));
            end
            S_DSTART: div_start = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_v      <= i_voltage_uv;
                    r_temp   <= '0;
                    r_status <= ST_CFG_ERR;
                end
                S_HI: begin
                    r_temp   <= r_first;
                    r_status <= ST_CLAMP_HI;
                end
                S_LO: begin
                    r_temp   <= r_first + TEMP_W'(n_m1 * step);
                    r_status <= ST_CLAMP_LO;
                    r_idx    <= '0;
                end
                S_WALK: begin
                    // Base temperature of the segment whose lower knot is this one.
                    r_temp   <= r_first + TEMP_W'(seg * step);
                    r_status <= ST_IN_RANGE;
                    r_den    <= r_prev - knot_uv;
                    if (!walk_stop) begin
                        r_prev <= knot_uv;
                        r_idx  <= r_idx + CW'(1);
                    end
                end
                S_MUL: r_num <= PROD_W'(hv_diff) * PROD_W'(step);
                S_DWAIT: begin
                    if (div_done) begin
                        r_temp <= r_temp + div_quot;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_out_valid  <= 1'b1;
                r_out_temp   <= r_temp;
                r_out_status <= r_status;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    stli_div #(
        .DEN_W (UV_W),
        .Q_W   (TEMP_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall    = in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_temperature = r_out_temp;
    assign o_status      = r_out_status;

    `STLI_ASSERT_NEXT(a_cfg_err_result,
        in_acc && i_action == ACT_CONVERT && cfg_err,
        r_state == S_FIN && r_status == ST_CFG_ERR && r_temp == '0,
        "bad configuration did not go straight to an error result")
    `STLI_ASSERT_NEXT(a_load_stays_idle,
        in_acc && i_action == ACT_LOAD,
        r_state == S_IDLE,
        "a load beat left the idle state")
    `STLI_ASSERT_NOW(a_walk_in_table,
        r_state == S_WALK,
        r_idx < n,
        "table walk ran past the last knot")
    `STLI_ASSERT_NOW(a_div_done_waited,
        div_done,
        r_state == S_DWAIT,
        "divider finished outside its wait state")
    `STLI_ASSERT_NEXT(a_result_held,
        r_state == S_FIN && r_out_valid && i_out_stall,
        r_state == S_FIN,
        "result left its work register while the output was still full")

endmodule

// ===== sim/sensor_table_linear_interpolation_top_tb.sv =====
// Testbench for the sensor table interpolation block: random and directed beats, scoreboard check.
module sensor_table_linear_interpolation_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stli_pkg::*;

    localparam int MAX_KNOTS      = DEFAULT_MAX_POINTS;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_ITEMS    = 90;
    localparam int PRESSURE_PHASE = 5;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 150;
    localparam int LIMIT_NS       = 24_000_000;

    typedef struct packed {
        logic [TEMP_W-1:0]   temp;
        logic [STATUS_W-1:0] status;
    } reading_t;

    // Tracks the knot table and settings, predicts each conversion and
    // checks the readings that come back in order.
    class reading_tracker;
        logic [COUNT_W-1:0] point_count;
        logic [TEMP_W-1:0]  t_first;
        logic [TEMP_W-1:0]  t_second;
        logic [KNOT_W-1:0]  knots [MAX_KNOTS];
        reading_t           due_readings [$];
        int                 errors;
        int                 n_loads;
        int                 n_converts;
        int                 status_seen [4];

        function new();
            point_count = '0;
            t_first     = '0;
            t_second    = '0;
            errors      = 0;
            n_loads     = 0;
            n_converts  = 0;
            foreach (status_seen[s]) status_seen[s] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_POINT_COUNT: point_count = data[COUNT_W-1:0];
                REG_FIRST_TEMP:  t_first     = data[TEMP_W-1:0];
                REG_SECOND_TEMP: t_second    = data[TEMP_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned knot_uv(longint unsigned i);
            return 64'(knots[i]) * 64'(UV_PER_UNIT);
        endfunction

        function reading_t predict_reading(logic [VOLT_W-1:0] v);
            reading_t res;
            longint unsigned n, step, base, hi, lo, val, i, seg, vv;
            vv = 64'(v);
            n  = 64'(point_count);
            if (n > MAX_KNOTS) n = MAX_KNOTS;
            res.temp   = '0;
            res.status = ST_CFG_ERR;
            if (n == 0 || t_first >= t_second) return res;
            step = 64'(t_second) - 64'(t_first);
            if (vv > knot_uv(0)) begin
                res.temp   = t_first;
                res.status = ST_CLAMP_HI;
                return res;
            end
            if (vv < knot_uv(n - 1)) begin
                val        = 64'(t_first) + (n - 1) * step;
                res.temp   = TEMP_W'(val);
                res.status = ST_CLAMP_LO;
                return res;
            end
            // Walk down to the first knot at or below the voltage.
            i = 0;
            while (i < n - 1 && vv < knot_uv(i)) i++;
            seg  = (i > 0) ? i - 1 : 0;
            base = 64'(t_first) + seg * step;
            val  = base;
            hi   = knot_uv(seg);
            if (vv != hi && seg + 1 < n) begin
                lo = knot_uv(seg + 1);
                if (hi > lo && hi > vv) val = base + ((hi - vv) * step) / (hi - lo);
            end
            res.temp   = TEMP_W'(val);
            res.status = ST_IN_RANGE;
            return res;
        endfunction

        function void note_input(logic act, logic [VOLT_W-1:0] v, logic [IDX_IN_W-1:0] idx,
                                 logic [KNOT_W-1:0] kv);
            reading_t r;
            if (act == ACT_LOAD) begin
                if (idx < MAX_KNOTS) knots[idx] = kv;
                n_loads++;
            end else begin
                r = predict_reading(v);
                due_readings.push_back(r);
                status_seen[r.status]++;
                n_converts++;
            end
        endfunction

        task log_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [TEMP_W-1:0] temp, logic [STATUS_W-1:0] status);
            reading_t want;
            if (due_readings.size() == 0) begin
                log_mismatch($sformatf("reading %0d/%0d with none outstanding", temp, status));
            end else begin
                want = due_readings.pop_front();
                if (temp !== want.temp)
                    log_mismatch($sformatf("temperature %0d, predicted %0d (status %0d)",
                                           temp, want.temp, want.status));
                if (status !== want.status)
                    log_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_action;
    logic [VOLT_W-1:0]     i_voltage_uv;
    logic [IDX_IN_W-1:0]   i_knot_index;
    logic [KNOT_W-1:0]     i_knot_voltage;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [TEMP_W-1:0]     o_temperature;
    logic [STATUS_W-1:0]   o_status;

    reading_tracker sb;
    int unsigned    send_idle_pct;
    int unsigned    stall_pct;
    logic           hold_rx;
    bit             hold_req;
    int             n_settings;

    sensor_table_linear_interpolation_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_voltage_uv   (i_voltage_uv),
        .i_knot_index   (i_knot_index),
        .i_knot_voltage (i_knot_voltage),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_temperature  (o_temperature),
        .o_status       (o_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= hold_rx || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_temperature, o_status);
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial begin
        hold_rx = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

    // Offers one beat and returns in the step of the edge that took it.
    task automatic send_item(input logic act, input logic [VOLT_W-1:0] v,
                             input logic [IDX_IN_W-1:0] idx, input logic [KNOT_W-1:0] kv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_voltage_uv   <= v;
        i_knot_index   <= idx;
        i_knot_voltage <= kv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(act, v, idx, kv);
    endtask

    task automatic load_knot(input int unsigned idx, input int unsigned kv);
        send_item(ACT_LOAD, VOLT_W'($urandom), IDX_IN_W'(idx), KNOT_W'(kv));
    endtask

    task automatic convert_uv(input logic [VOLT_W-1:0] v);
        send_item(ACT_CONVERT, v, IDX_IN_W'($urandom), KNOT_W'($urandom));
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (sb.due_readings.size() != 0) @(posedge i_clk);
        // Loads give no reading, so let any trailing work drain as well.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned n, input int unsigned t1, input int unsigned t2);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_POINT_COUNT;
        i_cfg_data  <= CFG_DATA_W'(n);
        @(posedge i_clk);
        sb.set_reg(REG_POINT_COUNT, CFG_DATA_W'(n));
        i_cfg_index <= REG_FIRST_TEMP;
        i_cfg_data  <= CFG_DATA_W'(t1);
        @(posedge i_clk);
        sb.set_reg(REG_FIRST_TEMP, CFG_DATA_W'(t1));
        i_cfg_index <= REG_SECOND_TEMP;
        i_cfg_data  <= CFG_DATA_W'(t2);
        @(posedge i_clk);
        sb.set_reg(REG_SECOND_TEMP, CFG_DATA_W'(t2));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly falling knots, with the odd flat or rising step mixed in.
    task automatic load_knot_ladder(input int unsigned n);
        int kv, max_gap;
        kv      = ($urandom_range(3) == 0) ? 65535 : int'($urandom_range(65535, n * 10));
        max_gap = (kv / int'(n)) + 1;
        for (int i = 0; i < int'(n); i++) begin
            load_knot(i, kv);
            case ($urandom_range(9))
                0: kv = kv + int'($urandom_range(400));
                1: ;
                default: kv = kv - int'($urandom_range(max_gap, 1));
            endcase
            if (kv > 65535) kv = 65535;
            if (kv < 0) kv = 0;
        end
    endtask

    function automatic logic [VOLT_W-1:0] pick_voltage(input int unsigned n);
        int unsigned r, j, top_uv, bot_uv, a, b;
        if (n == 0) return VOLT_W'($urandom);
        r      = $urandom_range(99);
        top_uv = int'(sb.knots[0]) * UV_PER_UNIT;
        bot_uv = int'(sb.knots[n-1]) * UV_PER_UNIT;
        if (r < 55 && n > 1) begin
            j = $urandom_range(n - 2);
            a = int'(sb.knots[j]) * UV_PER_UNIT;
            b = int'(sb.knots[j+1]) * UV_PER_UNIT;
            return VOLT_W'($urandom_range(a, b));
        end
        if (r < 70) return VOLT_W'(int'(sb.knots[$urandom_range(n - 1)]) * UV_PER_UNIT);
        if (r < 80) return VOLT_W'($urandom_range(24'hFFFFFF, top_uv + 1));
        if (r < 90 && bot_uv > 0) return VOLT_W'($urandom_range(bot_uv - 1, 0));
        return VOLT_W'($urandom);
    endfunction

    initial begin
        sb             = new();
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_req       = 1'b0;
        n_settings     = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_action       = ACT_CONVERT;
        i_voltage_uv   = '0;
        i_knot_index   = '0;
        i_knot_voltage = '0;
        i_out_stall    = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every knot is written before any conversion can read it.
        load_knot_ladder(MAX_KNOTS);

        // Bad settings: no knots, equal temperatures, falling temperatures.
        set_config(0, 100, 200);
        convert_uv(24'd5_000_000);
        set_config(4, 300, 300);
        convert_uv(24'd5_000_000);
        set_config(4, 65535, 0);
        convert_uv(24'd5_000_000);

        // Small table with a flat segment and a rising one before the last knot.
        load_knot(0, 65535);
        load_knot(1, 40000);
        load_knot(2, 40000);
        load_knot(3, 45000);
        load_knot(4, 1000);
        set_config(5, 0, 65535);
        convert_uv(24'hFFFFFF);
        convert_uv(24'd6_553_501);
        convert_uv(24'd6_553_500);
        convert_uv(24'd5_000_000);
        convert_uv(24'd4_000_000);
        convert_uv(24'd3_999_999);
        convert_uv(24'd4_500_000);
        convert_uv(24'd100_000);
        convert_uv(24'd99_999);
        convert_uv(24'd0);
        convert_uv(24'd100_001);

        // Single knot: only clamps or the base temperature are possible.
        set_config(1, 65534, 65535);
        convert_uv(24'd6_553_500);
        convert_uv(24'd1);
        convert_uv(24'd7_000_000);

        for (int p = 0; p < NUM_PHASES; p++) begin
            int unsigned n_cfg, t1, t2, n_eff, r;
            t1    = $urandom_range(65534);
            t2    = $urandom_range(65535, t1 + 1);
            n_cfg = $urandom_range(64, 1);
            case (p)
                0: begin n_cfg = 64; t1 = 0; t2 = 65535; end
                1: begin n_cfg = 2; t1 = 65534; t2 = 65535; end
                2: n_cfg = 127;
                3: n_cfg = 1;
                4: n_cfg = 0;
                6: begin n_cfg = 33; t1 = 0; t2 = 1; end
                7: n_cfg = 65;
                8: begin t1 = $urandom_range(65535, 1); t2 = $urandom_range(t1); end
                default: ;
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            set_config(n_cfg, t1, t2);
            n_eff = (n_cfg > MAX_KNOTS) ? MAX_KNOTS : n_cfg;
            if (n_eff > 0) load_knot_ladder(n_eff);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == PRESSURE_PHASE && k == 10) hold_req = 1'b1;
                r = $urandom_range(99);
                if (r < 8) begin
                    if (r < 5 && n_eff > 0) load_knot($urandom_range(n_eff - 1), $urandom);
                    else load_knot($urandom_range(MAX_KNOTS - 1), $urandom);
                end else begin
                    convert_uv(pick_voltage(n_eff));
                end
            end
        end

        quiesce();
        $display("Covered %0d conversions (%0d in range, %0d clamped high, %0d clamped low,",
                 sb.n_converts, sb.status_seen[ST_IN_RANGE], sb.status_seen[ST_CLAMP_HI],
                 sb.status_seen[ST_CLAMP_LO]);
        $display("  %0d with bad settings) and %0d knot writes over %0d register settings.",
                 sb.status_seen[ST_CFG_ERR], sb.n_loads, n_settings);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/stli_pkg.sv
design/stli_div.sv
design/sensor_table_linear_interpolation_top.sv
sim/sensor_table_linear_interpolation_top_tb.sv
